FILE: hw/rtl/afsp_pkg.sv
// Shared types, constants and the sampling rate table of the ADTS frame sync parser.
package afsp_pkg;

    localparam int unsigned HeaderBytes     = 7;
    localparam int unsigned SamplesPerFrame = 1024;
    localparam int unsigned NumRates        = 13;

    localparam int unsigned LenW   = 13;
    localparam int unsigned IdxW   = 4;
    localparam int unsigned RateW  = 17;
    localparam int unsigned TsW    = 32;
    localparam int unsigned SkipW  = 16;

    localparam logic [7:0] SyncByte   = 8'hFF;
    localparam logic [3:0] SyncNibble = 4'hF;

    // One result item
    typedef struct packed {
        logic [LenW-1:0]  frame_length;
        logic [IdxW-1:0]  rate_index;
        logic [RateW-1:0] sample_rate;
        logic [TsW-1:0]   frame_timestamp;
        logic [SkipW-1:0] skipped_bytes;
        logic             bad_rate;
        logic             bad_length;
    } t_afsp_result;

    // Sampling frequency in Hz for a valid index
    function automatic logic [RateW-1:0] rate_lookup(input logic [IdxW-1:0] idx);
        logic [RateW-1:0] hz;
        case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = '0;
        endcase
        return hz;
    endfunction

endpackage

FILE: hw/rtl/adts_frame_sync_parser.sv
// Top level of the ADTS frame sync parser: byte handshake, parse state, result register, APB.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------------
//  in       | input     | i_in_valid/o_in_ready   | i_stream_byte
//  out      | output    | o_out_valid/i_out_ready | o_frame_length .. o_bad_length
//  config   | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// One byte per clock unless the input stalls: each byte updates the parse state in the cycle it is accepted,
// and the seventh header byte loads the result register at that same edge.
// A finished result waits in the output register; a new byte is taken while it is
// being read out, and input stalls only while that register is full and not taken.
// Reset (synchronous, active low) starts hunting with zeroed counts and timestamp.
module adts_frame_sync_parser #(
    parameter int unsigned SAMPLES_PER_FRAME = afsp_pkg::SamplesPerFrame
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_stream_byte,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [afsp_pkg::LenW-1:0]   o_frame_length,
    output logic [afsp_pkg::IdxW-1:0]   o_rate_index,
    output logic [afsp_pkg::RateW-1:0]  o_sample_rate,
    output logic [afsp_pkg::TsW-1:0]    o_frame_timestamp,
    output logic [afsp_pkg::SkipW-1:0]  o_skipped_bytes,
    output logic                        o_bad_rate,
    output logic                        o_bad_length,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import afsp_pkg::*;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_HEADER,
        MODE_PAYLOAD
    } t_mode;

    localparam logic [1:0] AddrTsStart = 2'd0;
    localparam logic [2:0] LastHdrCnt  = 3'(HeaderBytes - 1);

    t_mode            r_mode, n_mode;
    logic             r_saw_ff, n_saw_ff;
    logic [2:0]       r_hdr_cnt, n_hdr_cnt;
    logic [7:0]       r_byte2, n_byte2;
    logic [7:0]       r_byte3, n_byte3;
    logic [7:0]       r_byte4, n_byte4;
    logic [7:0]       r_byte5, n_byte5;
    logic [LenW-1:0]  r_payload_left, n_payload_left;
    logic [TsW-1:0]   r_ts_start;
    logic [TsW-1:0]   r_running_ts, n_running_ts;
    logic [RateW-1:0] r_current_rate, n_current_rate;
    logic [SkipW-1:0] r_skip_count, n_skip_count;
    logic             r_out_valid, n_out_valid;
    t_afsp_result     r_out;

    logic             in_fire;
    logic             cfg_write;
    logic             emit;
    logic [1:0]       skip_inc;
    logic [SkipW:0]   skip_sum;
    t_afsp_result     dec_result;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready && (paddr == AddrTsStart);
    assign prdata     = (paddr == AddrTsStart) ? r_ts_start : '0;

    // Header decode
    afsp_hdr_decode #(
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
    ) u_decode (
        .i_byte2        (r_byte2),
        .i_byte3        (r_byte3),
        .i_byte4        (r_byte4),
        .i_byte5        (r_byte5),
        .i_current_rate (r_current_rate),
        .i_running_ts   (r_running_ts),
        .i_skip_count   (r_skip_count),
        .o_result       (dec_result)
    );

    // Saturating skip counter: a failed held 0xFF and a non-0xFF byte may both count
    assign skip_inc = {1'b0, r_saw_ff} + {1'b0, (i_stream_byte != SyncByte)};
    assign skip_sum = {1'b0, r_skip_count} + (SkipW+1)'(skip_inc);

    // Next-state logic
    always_comb begin
        n_mode         = r_mode;
        n_saw_ff       = r_saw_ff;
        n_hdr_cnt      = r_hdr_cnt;
        n_byte2        = r_byte2;
        n_byte3        = r_byte3;
        n_byte4        = r_byte4;
        n_byte5        = r_byte5;
        n_payload_left = r_payload_left;
        n_running_ts   = r_running_ts;
        n_current_rate = r_current_rate;
        n_skip_count   = r_skip_count;
        n_out_valid    = r_out_valid && !i_out_ready;
        emit           = 1'b0;

        if (in_fire) begin
            unique case (r_mode)
                MODE_PAYLOAD: begin
                    n_payload_left = (r_payload_left != '0) ? r_payload_left - 1'b1
                                                            : r_payload_left;
                    if (n_payload_left == '0) begin
                        n_mode = MODE_HUNT;
                    end
                end
                MODE_HEADER: begin
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                    case (r_hdr_cnt)
                        3'd2:    n_byte2 = i_stream_byte;
                        3'd3:    n_byte3 = i_stream_byte;
                        3'd4:    n_byte4 = i_stream_byte;
                        3'd5:    n_byte5 = i_stream_byte;
                        default: ;
                    endcase
                    if (r_hdr_cnt == LastHdrCnt) begin
                        emit           = 1'b1;
                        n_out_valid    = 1'b1;
                        n_current_rate = dec_result.sample_rate;
                        n_running_ts   = dec_result.frame_timestamp;
                        n_skip_count   = '0;
                        n_hdr_cnt      = '0;
                        n_saw_ff       = 1'b0;
                        if (dec_result.bad_length ||
                            dec_result.frame_length == LenW'(HeaderBytes)) begin
                            n_payload_left = '0;
                            n_mode         = MODE_HUNT;
                        end else begin
                            n_payload_left = dec_result.frame_length - LenW'(HeaderBytes);
                            n_mode         = MODE_PAYLOAD;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_HUNT;
                    if (r_saw_ff && i_stream_byte[7:4] == SyncNibble) begin
                        n_saw_ff  = 1'b0;
                        n_hdr_cnt = 3'd2;
                        n_mode    = MODE_HEADER;
                    end else begin
                        n_saw_ff     = (i_stream_byte == SyncByte);
                        n_skip_count = skip_sum[SkipW] ? '1 : skip_sum[SkipW-1:0];
                    end
                end
            endcase
        end

        // Timestamp register write reloads the running timestamp
        if (cfg_write) begin
            n_running_ts = pwdata;
        end
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_HUNT;
            r_saw_ff       <= 1'b0;
            r_hdr_cnt      <= '0;
            r_payload_left <= '0;
            r_ts_start     <= '0;
            r_running_ts   <= '0;
            r_current_rate <= '0;
            r_skip_count   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_mode         <= n_mode;
            r_saw_ff       <= n_saw_ff;
            r_hdr_cnt      <= n_hdr_cnt;
            r_payload_left <= n_payload_left;
            r_running_ts   <= n_running_ts;
            r_current_rate <= n_current_rate;
            r_skip_count   <= n_skip_count;
            r_out_valid    <= n_out_valid;
            if (cfg_write) begin
                r_ts_start <= pwdata;
            end
        end
        r_byte2 <= n_byte2;
        r_byte3 <= n_byte3;
        r_byte4 <= n_byte4;
        r_byte5 <= n_byte5;
        if (emit) begin
            r_out <= dec_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_length    = r_out.frame_length;
    assign o_rate_index      = r_out.rate_index;
    assign o_sample_rate     = r_out.sample_rate;
    assign o_frame_timestamp = r_out.frame_timestamp;
    assign o_skipped_bytes   = r_out.skipped_bytes;
    assign o_bad_rate        = r_out.bad_rate;
    assign o_bad_length      = r_out.bad_length;

endmodule

FILE: hw/rtl/afsp_hdr_decode.sv
// Header field extraction, rate lookup and timestamp advance for one completed header.
module afsp_hdr_decode #(
    parameter int unsigned SAMPLES_PER_FRAME = afsp_pkg::SamplesPerFrame
) (
    input  logic [7:0]                  i_byte2,
    input  logic [7:0]                  i_byte3,
    input  logic [7:0]                  i_byte4,
    input  logic [7:0]                  i_byte5,
    input  logic [afsp_pkg::RateW-1:0]  i_current_rate,
    input  logic [afsp_pkg::TsW-1:0]    i_running_ts,
    input  logic [afsp_pkg::SkipW-1:0]  i_skip_count,
    output afsp_pkg::t_afsp_result      o_result
);
    import afsp_pkg::*;

    localparam logic [TsW-1:0] TsStep = TsW'(SAMPLES_PER_FRAME);

    logic [IdxW-1:0] idx;
    logic [LenW-1:0] len;
    logic            bad_rate;
    logic            bad_len;

    // Field extraction
    assign idx      = i_byte2[5:2];
    assign len      = {i_byte3[1:0], i_byte4, i_byte5[7:5]};
    assign bad_rate = (idx >= IdxW'(NumRates));
    assign bad_len  = (len < LenW'(HeaderBytes));

    // Result assembly; invalid index keeps the old rate, short length keeps the timestamp
    always_comb begin
        o_result.frame_length    = len;
        o_result.rate_index      = idx;
        o_result.sample_rate     = bad_rate ? i_current_rate : rate_lookup(idx);
        o_result.frame_timestamp = bad_len ? i_running_ts : i_running_ts + TsStep;
        o_result.skipped_bytes   = i_skip_count;
        o_result.bad_rate        = bad_rate;
        o_result.bad_length      = bad_len;
    end

endmodule

FILE: hw/rtl/afsp_checker.sv
// Port-level checks for the ADTS frame sync parser, bound to its top level.
module afsp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [afsp_pkg::LenW-1:0]   o_frame_length,
    input logic [afsp_pkg::IdxW-1:0]   o_rate_index,
    input logic                        o_bad_rate,
    input logic                        o_bad_length
);
    import afsp_pkg::*;

    // A pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // An empty output register never stalls the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // A new result comes only from an accepted byte
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without an accepted item");

    // Length flag agrees with the reported length
    a_len_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bad_length == (o_frame_length < LenW'(HeaderBytes))))
        else $error("bad_length disagrees with frame_length");

    // Rate flag agrees with the reported index
    a_rate_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bad_rate == (o_rate_index >= IdxW'(NumRates))))
        else $error("bad_rate disagrees with rate_index");

endmodule

bind adts_frame_sync_parser afsp_checker u_afsp_checker (.*);
